FILE: rtl/sspv_pkg.sv
// Shared types and constants for the sliced sample playback voice.
package sspv_pkg;

  localparam int unsigned SAMPLE_DEPTH = 65536;
  localparam int unsigned ADDR_W       = 16;
  localparam int unsigned SAMPLE_BITS  = 16;
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned MAX_SLICES   = 128;
  localparam int unsigned CNT_W        = 17;   // sample count width
  localparam int unsigned POS_W        = 33;   // play position width
  localparam int unsigned DIV_STEPS    = 17;

  localparam logic [19:0] SPD_MIN = 20'd13107;   // round(0.2 * 2^16)
  localparam logic [19:0] SPD_MAX = 20'd655360;  // 10 * 2^16

  // register indexes
  localparam logic [2:0] REG_TRIG  = 3'd0;
  localparam logic [2:0] REG_READ  = 3'd1;
  localparam logic [2:0] REG_SLICE = 3'd2;
  localparam logic [2:0] REG_COUNT = 3'd3;
  localparam logic [2:0] REG_CHAN  = 3'd4;
  localparam logic [2:0] REG_PULSE = 3'd5;

  // mode codes
  localparam logic [1:0] TM_TRIG  = 2'd0;
  localparam logic [1:0] TM_GATE  = 2'd1;
  localparam logic [1:0] TM_SLICE = 2'd2;
  localparam logic [1:0] RM_FWD   = 2'd0;
  localparam logic [1:0] RM_BWD   = 2'd1;
  localparam logic [1:0] RM_REP   = 2'd2;
  localparam logic [1:0] CM_STEREO = 2'd1;
  localparam logic [1:0] CM_SUM    = 2'd2;

  localparam logic [7:0] SLICE_NONE = 8'hFF;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DIV1, ST_DIV2, ST_PRE, ST_TRIG, ST_SLST, ST_BND, ST_ADDR,
    ST_RD1, ST_RD2, ST_ML1, ST_ML2, ST_MR1, ST_MR2, ST_ADV, ST_END, ST_OUT
  } state_e;

endpackage

FILE: rtl/sspv_div.sv
// Restoring divider, one quotient bit per cycle.
module sspv_div
  import sspv_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CNT_W-1:0] dividend_i,
  input  logic [7:0]       divisor_i,
  output logic             done_o,
  output logic [CNT_W-1:0] quot_o,
  output logic [7:0]       rem_o
);

  logic [CNT_W-1:0] quo_q;
  logic [7:0]       rem_q;
  logic [4:0]       cnt_q;
  logic             done_q;
  logic [8:0]       part;
  logic [9:0]       trial;

  assign part  = {rem_q, quo_q[CNT_W-1]};
  assign trial = {1'b0, part} - {2'b00, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= 5'(DIV_STEPS);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 5'd1;
      done_q <= (cnt_q == 5'd1);
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      if (!trial[9]) begin
        rem_q <= trial[7:0];
        quo_q <= {quo_q[CNT_W-2:0], 1'b1};
      end else begin
        rem_q <= part[7:0];
        quo_q <= {quo_q[CNT_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

FILE: rtl/sliced_sample_playback_voice.sv
// Sliced sample playback voice: sample memory, play control and interpolation.
// Load transaction: the result is registered once the output is free; no further input is
// taken before that. Tick transaction: two divider passes for slice length and slice wrap,
// then, while playing, two reads of the sample memory and four multiply steps; when silent
// the reads and multiply steps are skipped.
// One transaction in flight; the next is accepted while a result waits at the output.
// Reset (async, active low) clears control and play state; sample memory is not cleared.
module sliced_sample_playback_voice
  import sspv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] load_addr, [31:16] load_left, [47:32] load_right, [48] gate_high,
  // [59:49] pos_cv, [60] pos_connected, [61] reset_high, [81:62] speed_q16
  input  logic [87:0] s_axis_tdata,
  input  logic        s_axis_tuser,   // [0] op
  // stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] out_left, [31:16] out_right, [32] end_pulse, [33] playing
  output logic [39:0] m_axis_tdata,
  // config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------- configuration registers ----------------
  logic [1:0]  trig_mode_q, read_mode_q, chan_mode_q;
  logic [7:0]  slice_cnt_q;
  logic [16:0] sample_cnt_q;
  logic [15:0] pulse_len_q;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_mode_q  <= 2'd0;
      read_mode_q  <= 2'd0;
      slice_cnt_q  <= 8'd1;
      sample_cnt_q <= '0;
      chan_mode_q  <= 2'd0;
      pulse_len_q  <= 16'd48;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_TRIG:  trig_mode_q  <= pwdata[1:0];
        REG_READ:  read_mode_q  <= pwdata[1:0];
        REG_SLICE: slice_cnt_q  <= pwdata[7:0];
        REG_COUNT: sample_cnt_q <= pwdata[16:0];
        REG_CHAN:  chan_mode_q  <= pwdata[1:0];
        REG_PULSE: pulse_len_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TRIG:  prdata = {30'd0, trig_mode_q};
      REG_READ:  prdata = {30'd0, read_mode_q};
      REG_SLICE: prdata = {24'd0, slice_cnt_q};
      REG_COUNT: prdata = {15'd0, sample_cnt_q};
      REG_CHAN:  prdata = {30'd0, chan_mode_q};
      REG_PULSE: prdata = {16'd0, pulse_len_q};
      default:   prdata = '0;
    endcase
  end

  // effective settings
  logic [CNT_W-1:0] n_w, n_m1;
  logic [7:0]       ns_w;
  logic [1:0]       tm, rm;
  logic [POS_W-1:0] lim;

  assign n_w  = (sample_cnt_q > 17'(SAMPLE_DEPTH)) ? 17'(SAMPLE_DEPTH) : sample_cnt_q;
  assign n_m1 = n_w - 17'd1;
  assign ns_w = (slice_cnt_q == 8'd0) ? 8'd1 :
                (slice_cnt_q > 8'(MAX_SLICES)) ? 8'(MAX_SLICES) : slice_cnt_q;
  assign tm   = (trig_mode_q == 2'd3) ? TM_TRIG : trig_mode_q;
  assign rm   = (read_mode_q == 2'd3) ? RM_FWD : read_mode_q;
  assign lim  = {n_w, 16'd0};

  // ---------------- control ----------------
  state_e state_q, state_d;
  logic   in_acc, div_start, div_done;
  logic [CNT_W-1:0] div_dividend, div_quot;
  logic [7:0]       div_rem;
  logic             out_free;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // datapath state
  logic [POS_W-1:0] pos_q, cvpos_q;
  logic             flag_q, gprev_q, rprev_q, armed_q, edge_q, active_q;
  logic [7:0]       slice_q, cvsl_q, wrap_q;
  logic [15:0]      pulse_q;
  logic [CNT_W-1:0] len_q;
  logic [24:0]      lo_q;
  logic [25:0]      hi_q;
  logic [15:0]      xn_q;
  logic [31:0]      sa_q;
  logic [15:0]      la_q, lb_q, ra_q, rb_q;
  logic [32:0]      prod_q;
  logic [15:0]      ol_q, or_q;
  logic             ep_q, pl_q;
  // captured tick inputs
  logic             gate_q, conn_q, rst_q;
  logic [10:0]      cv_q;
  logic [19:0]      spd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = s_axis_tuser ? ST_DIV1 : ST_OUT;
      ST_DIV1: if (div_done) state_d = ST_DIV2;
      ST_DIV2: if (div_done) state_d = ST_PRE;
      ST_PRE:  state_d = ST_TRIG;
      ST_TRIG: state_d = ST_SLST;
      ST_SLST: state_d = ST_BND;
      ST_BND:  state_d = ST_ADDR;
      ST_ADDR: state_d = (flag_q && pos_q < lim) ? ST_RD1 : ST_END;
      ST_RD1:  state_d = ST_RD2;
      ST_RD2:  state_d = ST_ML1;
      ST_ML1:  state_d = ST_ML2;
      ST_ML2:  state_d = ST_MR1;
      ST_MR1:  state_d = ST_MR2;
      ST_MR2:  state_d = ST_ADV;
      ST_ADV:  state_d = ST_END;
      ST_END:  state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // sample memory read address, divider launch
  logic [ADDR_W-1:0] rd_addr;
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    div_start     = 1'b0;
    div_dividend  = n_w;
    rd_addr       = pos_q[31:16];
    unique case (state_q)
      ST_IDLE: div_start = in_acc && s_axis_tuser;
      ST_DIV1: begin
        div_start    = div_done;
        div_dividend = {8'd0, slice_q + 8'd1} + ((slice_q == SLICE_NONE) ? 17'h100 : 17'd0);
      end
      ST_RD1:  rd_addr = xn_q;
      default: ;
    endcase
  end

  sspv_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (ns_w),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // ---------------- sample memory ----------------
  logic [31:0] mem [SAMPLE_DEPTH];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && !s_axis_tuser) mem[s_axis_tdata[15:0]] <= s_axis_tdata[47:16];
    rdata_q <= mem[rd_addr];
  end

  // ---------------- datapath helpers ----------------
  logic [27:0] cv_prod;
  logic [33:0] cv_p;
  logic [18:0] cvsl_prod;
  logic [8:0]  cvsl_raw;
  logic [24:0] st_fwd, st_bwd, st_sel, st_clamp;
  logic [7:0]  si;
  logic [15:0] xi, r_l, r_r, a_l, a_r;
  logic [16:0] xi1;
  logic [16:0] onef;
  logic [15:0] frac;
  logic [32:0] mul_a, mul_b_sum;
  logic [32:0] p_step;
  logic [16:0] pi;
  logic        hi_hit, lo_hit;
  logic [24:0] lo_cl;
  logic        armed_n;
  logic [15:0] pulse_n;

  assign cv_prod   = cv_q * n_m1;
  assign cv_p      = {cv_prod, 6'd0};
  assign cvsl_prod = cv_q * ns_w;
  assign cvsl_raw  = cvsl_prod[18:10];

  assign st_fwd   = {17'd0, slice_q} * {8'd0, len_q};
  assign st_bwd   = ({17'd0, slice_q} + 25'd1) * {8'd0, len_q} - 25'd1;
  assign st_sel   = (rm != RM_BWD) ? st_fwd : st_bwd;
  assign st_clamp = (n_w == '0) ? 25'd0 : (st_sel > {8'd0, n_m1}) ? {8'd0, n_m1} : st_sel;

  assign si  = (slice_q == SLICE_NONE) ? 8'd0 : slice_q;
  assign xi  = pos_q[31:16];
  assign xi1 = {1'b0, xi} + 17'd1;

  assign frac = pos_q[15:0];
  assign onef = 17'h10000 - {1'b0, frac};
  assign mul_a = (state_q == ST_ML1) ? la_q * onef : ra_q * onef;
  assign mul_b_sum = prod_q + ((state_q == ST_ML2) ? lb_q * frac : rb_q * frac) + 33'h8000;

  // position advance and end checks
  always_comb begin
    if (tm == TM_GATE)      p_step = pos_q;
    else if (rm != RM_BWD)  p_step = pos_q + {13'd0, spd_q};
    else                    p_step = (pos_q > {13'd0, spd_q}) ? pos_q - {13'd0, spd_q} : '0;
    pi     = p_step[32:16];
    hi_hit = ({9'd0, pi} >= hi_q) || (p_step >= lim);
    lo_hit = ({8'd0, pi} < lo_q) || (({8'd0, pi} == lo_q) && (p_step[15:0] == '0))
             || (p_step == '0);
    lo_cl  = (lo_q > {8'd0, n_w}) ? {8'd0, n_w} : lo_q;
  end

  // summed or split channel words
  function automatic logic [15:0] avg2(input logic [15:0] l, input logic [15:0] r);
    logic [16:0] s;
    s = {l[15], l} + {r[15], r};
    return s[16:1];
  endfunction

  always_comb begin
    r_l = rdata_q[15:0];
    r_r = rdata_q[31:16];
    a_l = sa_q[15:0];
    a_r = sa_q[31:16];
  end

  assign armed_n = armed_q || flag_q;
  assign pulse_n = (armed_n && !flag_q) ? pulse_len_q : pulse_q;

  // ---------------- control state ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      flag_q  <= 1'b0;
      slice_q <= SLICE_NONE;
      gprev_q <= 1'b0;
      rprev_q <= 1'b0;
      armed_q <= 1'b0;
      pulse_q <= '0;
      edge_q  <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (state_q == ST_OUT && out_free) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready)            m_axis_tvalid <= 1'b0;
      unique case (state_q)
        ST_TRIG: begin
          edge_q <= (tm == TM_SLICE) && gate_q && !gprev_q;
          unique case (tm)
            TM_GATE: begin
              flag_q <= gate_q;
              pos_q  <= cvpos_q;
            end
            TM_SLICE: begin
              gprev_q <= gate_q;
              if (gate_q && !gprev_q) begin
                flag_q  <= 1'b1;
                slice_q <= conn_q ? cvsl_q : ((slice_q == SLICE_NONE) ? 8'd0 : wrap_q);
              end
            end
            default: begin
              gprev_q <= gate_q;
              if (gate_q && !gprev_q) begin
                flag_q <= 1'b1;
                if (conn_q)                          pos_q <= cvpos_q;
                else if (rm != RM_BWD || n_w == '0)  pos_q <= '0;
                else                                 pos_q <= {n_m1, 16'd0};
              end
            end
          endcase
        end
        ST_SLST: begin
          // position reset edge wins over the slice start
          if (rst_q && !rprev_q) begin
            slice_q <= 8'd0;
            pos_q   <= '0;
          end else if (edge_q) begin
            pos_q <= {st_clamp[16:0], 16'd0};
          end
          rprev_q <= rst_q;
        end
        ST_ADDR: begin
          if (!(flag_q && pos_q < lim) && pos_q == lim) flag_q <= 1'b0;
        end
        ST_ADV: begin
          if (tm == TM_TRIG && rm == RM_REP && p_step >= lim)     pos_q <= cvpos_q;
          else if (tm == TM_SLICE && rm == RM_REP && hi_hit)      pos_q <= {lo_cl[16:0], 16'd0};
          else                                                    pos_q <= p_step;
          if (tm == TM_TRIG) begin
            if (rm == RM_FWD && p_step >= lim) flag_q <= 1'b0;
            else if (rm == RM_BWD && p_step == '0) flag_q <= 1'b0;
          end else if (tm == TM_SLICE) begin
            if (rm == RM_FWD && hi_hit) flag_q <= 1'b0;
            if (rm == RM_BWD && lo_hit) flag_q <= 1'b0;
          end
        end
        ST_END: begin
          armed_q <= armed_n && flag_q;
          pulse_q <= (pulse_n != '0) ? pulse_n - 16'd1 : pulse_n;
        end
        default: ;
      endcase
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          gate_q <= s_axis_tdata[48];
          cv_q   <= s_axis_tdata[60] ? s_axis_tdata[59:49] : 11'd0;
          conn_q <= s_axis_tdata[60];
          rst_q  <= s_axis_tdata[61];
          spd_q  <= (s_axis_tdata[81:62] < SPD_MIN) ? SPD_MIN :
                    (s_axis_tdata[81:62] > SPD_MAX) ? SPD_MAX : s_axis_tdata[81:62];
          ol_q   <= '0;
          or_q   <= '0;
          ep_q   <= (pulse_q != '0);
          pl_q   <= flag_q;
        end
      end
      ST_DIV1: if (div_done) len_q <= (div_quot == '0) ? 17'd1 : div_quot;
      ST_DIV2: if (div_done) wrap_q <= div_rem;
      ST_PRE: begin
        if (n_w == '0)                 cvpos_q <= '0;
        else if (cv_p > {1'b0, n_m1, 16'd0}) cvpos_q <= {n_m1, 16'd0};
        else                           cvpos_q <= cv_p[32:0];
        cvsl_q <= (cvsl_raw > {1'b0, ns_w - 8'd1}) ? ns_w - 8'd1 : cvsl_raw[7:0];
      end
      ST_BND: begin
        lo_q <= {17'd0, si} * {8'd0, len_q};
        hi_q <= ({18'd0, si} + 26'd1) * {9'd0, len_q};
      end
      ST_ADDR: begin
        active_q <= flag_q && pos_q < lim;
        xn_q     <= (xi1 < n_w) ? xi1[15:0] : n_m1[15:0];
        ol_q     <= '0;
        or_q     <= '0;
      end
      ST_RD1: sa_q <= rdata_q;
      ST_RD2: begin
        unique case (chan_mode_q)
          CM_STEREO: begin
            la_q <= a_l ^ 16'h8000;  lb_q <= r_l ^ 16'h8000;
            ra_q <= a_r ^ 16'h8000;  rb_q <= r_r ^ 16'h8000;
          end
          CM_SUM: begin
            la_q <= avg2(a_l, a_r) ^ 16'h8000;  lb_q <= avg2(r_l, r_r) ^ 16'h8000;
            ra_q <= avg2(a_l, a_r) ^ 16'h8000;  rb_q <= avg2(r_l, r_r) ^ 16'h8000;
          end
          default: begin
            la_q <= a_l ^ 16'h8000;  lb_q <= r_l ^ 16'h8000;
            ra_q <= a_l ^ 16'h8000;  rb_q <= r_l ^ 16'h8000;
          end
        endcase
      end
      ST_ML1, ST_MR1: prod_q <= mul_a;
      ST_ML2: ol_q <= mul_b_sum[31:16] ^ 16'h8000;
      ST_MR2: or_q <= mul_b_sum[31:16] ^ 16'h8000;
      ST_END: begin
        ep_q <= (pulse_n != '0);
        pl_q <= flag_q;
        if (!active_q) begin
          ol_q <= '0;
          or_q <= '0;
        end
      end
      ST_OUT: if (out_free) m_axis_tdata <= {6'd0, pl_q, ep_q, or_q, ol_q};
      default: ;
    endcase
  end

endmodule

FILE: tb/tb_sliced_sample_playback_voice.sv
// Testbench for the sliced sample playback voice: random stream traffic checked by a predictor.
module tb_sliced_sample_playback_voice;
  import sspv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // one input transaction, fields as in the stream data
  typedef struct packed {
    logic        op;
    logic [15:0] addr;
    logic [15:0] left;
    logic [15:0] right;
    logic        gate;
    logic [10:0] cv;
    logic        conn;
    logic        rst;
    logic [19:0] speed;
  } voice_item_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic        pulse;
    logic        playing;
  } voice_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  sliced_sample_playback_voice dut (.*);

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------
  // Predictor state: its own copy of memory, registers and play state
  // ---------------------------------------------------------------
  logic [15:0] smp_l [int unsigned];
  logic [15:0] smp_r [int unsigned];
  logic [1:0]  trig_mode_q, read_mode_q, chan_mode_q;
  logic [7:0]  slices_q;
  logic [16:0] count_q;
  logic [15:0] pulse_len_q;
  logic [32:0] pos_q;
  logic        play_q, gate_q, rst_q, armed_q;
  logic [7:0]  slice_q;
  logic [15:0] pulse_left_q;

  voice_item_t pending_items[$];
  voice_out_t  expected_outs[$];
  int unsigned n_errors = 0;
  bit          tail_phase = 0;   // no idling near the end
  longint unsigned cycles = 0;

  task automatic queue_item(input voice_item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h (t=%0t)", what, got, want, $realtime);
    n_errors++;
  endtask

  function automatic logic [32:0] cv_to_pos(logic [10:0] cv, logic [16:0] n);
    logic [63:0] p, lim;
    if (n == 0) return '0;
    p = ((64'(cv) * (n - 1)) << FRAC_BITS) >> 10;
    lim = 64'(n - 1) << FRAC_BITS;
    return (p > lim) ? lim[32:0] : p[32:0];
  endfunction

  // a*(1-f)+b*f rounded half up, on offset-binary words
  function automatic logic [15:0] lerp(logic signed [15:0] a, logic signed [15:0] b,
                                       logic [15:0] f);
    logic [63:0] ua, ub, s;
    ua = 64'(a + 32768);
    ub = 64'(b + 32768);
    s = ua * (65536 - f) + ub * f + 32768;
    return 16'((s >> 16) - 32768);
  endfunction

  function automatic logic [15:0] mix_word(int unsigned i);
    logic [16:0] s;
    s = 17'({~smp_l[i][15], smp_l[i][14:0]}) + 17'({~smp_r[i][15], smp_r[i][14:0]});
    return {~s[16], s[15:1]};
  endfunction

  function automatic logic [15:0] rd_l(int unsigned i);
    return smp_l.exists(i) ? smp_l[i] : 16'h0;
  endfunction
  function automatic logic [15:0] rd_r(int unsigned i);
    return smp_r.exists(i) ? smp_r[i] : 16'h0;
  endfunction

  function automatic void write_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      REG_TRIG:  trig_mode_q = v[1:0];
      REG_READ:  read_mode_q = v[1:0];
      REG_SLICE: slices_q    = v[7:0];
      REG_COUNT: count_q     = v[16:0];
      REG_CHAN:  chan_mode_q = v[1:0];
      REG_PULSE: pulse_len_q = v[15:0];
      default: ;
    endcase
  endfunction

  // advance the voice by one transaction and return the result it makes
  function automatic voice_out_t voice_step(voice_item_t it);
    voice_out_t o;
    logic [16:0] n;
    logic [7:0]  ns;
    logic [63:0] len, spd, lim, si, st, lo, hi, xi, xn, sl;
    logic [15:0] xf;
    logic [1:0]  tm, rm;
    logic [10:0] cv;
    logic        edge_seen;
    o = '0;
    if (!it.op) begin
      smp_l[it.addr] = it.left;
      smp_r[it.addr] = it.right;
      o.pulse = pulse_left_q != 0;
      o.playing = play_q;
      return o;
    end
    n   = (count_q > SAMPLE_DEPTH) ? 17'(SAMPLE_DEPTH) : count_q;
    ns  = (slices_q < 1) ? 8'd1 : ((slices_q > MAX_SLICES) ? 8'(MAX_SLICES) : slices_q);
    len = 64'(n) / ns;
    if (len < 1) len = 1;
    tm  = (trig_mode_q > TM_SLICE) ? TM_TRIG : trig_mode_q;
    rm  = (read_mode_q > RM_REP) ? RM_FWD : read_mode_q;
    cv  = it.conn ? it.cv : 11'd0;
    lim = 64'(n) << FRAC_BITS;
    spd = 64'(it.speed);
    if (spd < SPD_MIN) spd = SPD_MIN;
    if (spd > SPD_MAX) spd = SPD_MAX;

    if (tm == TM_TRIG) begin
      edge_seen = it.gate && !gate_q;
      gate_q = it.gate;
      if (edge_seen) begin
        play_q = 1;
        if (it.conn) pos_q = cv_to_pos(cv, n);
        else pos_q = (rm != RM_BWD || n == 0) ? '0 : 33'(64'(n - 1) << FRAC_BITS);
      end
    end else if (tm == TM_GATE) begin
      play_q = it.gate;
      pos_q = cv_to_pos(cv, n);
    end else begin
      edge_seen = it.gate && !gate_q;
      gate_q = it.gate;
      if (edge_seen) begin
        play_q = 1;
        if (it.conn) begin
          sl = (64'(cv) * ns) >> 10;
          if (sl > ns - 1) sl = ns - 1;
          slice_q = sl[7:0];
        end else begin
          slice_q = (slice_q == SLICE_NONE) ? 8'd0 : 8'((64'(slice_q) + 1) % ns);
        end
        st = (rm != RM_BWD) ? 64'(slice_q) * len : (64'(slice_q) + 1) * len - 1;
        if (n == 0) st = 0;
        else if (st > n - 1) st = n - 1;
        pos_q = 33'(st << FRAC_BITS);
      end
    end

    if (it.rst && !rst_q) begin
      slice_q = 0;
      pos_q = 0;
    end
    rst_q = it.rst;
    si = (slice_q == SLICE_NONE) ? 0 : 64'(slice_q);

    if (play_q && 64'(pos_q) < lim) begin
      xi = 64'(pos_q) >> FRAC_BITS;
      xf = pos_q[15:0];
      xn = (xi + 1 < n) ? xi + 1 : n - 1;
      if (chan_mode_q == CM_STEREO) begin
        o.left = lerp(rd_l(xi), rd_l(xn), xf);
        o.right = lerp(rd_r(xi), rd_r(xn), xf);
      end else if (chan_mode_q == CM_SUM) begin
        o.left = lerp(mix_word(xi), mix_word(xn), xf);
        o.right = o.left;
      end else begin
        o.left = lerp(rd_l(xi), rd_l(xn), xf);
        o.right = o.left;
      end
      if (tm != TM_GATE) begin
        if (rm != RM_BWD) pos_q = 33'(64'(pos_q) + spd);
        else pos_q = (64'(pos_q) > spd) ? 33'(64'(pos_q) - spd) : '0;
      end
      if (tm == TM_TRIG) begin
        if (rm == RM_FWD && 64'(pos_q) >= lim) play_q = 0;
        else if (rm == RM_BWD && pos_q == 0) play_q = 0;
        else if (rm == RM_REP && 64'(pos_q) >= lim) pos_q = cv_to_pos(cv, n);
      end else if (tm == TM_SLICE) begin
        lo = (si * len) << FRAC_BITS;
        hi = ((si + 1) * len) << FRAC_BITS;
        if (rm == RM_FWD && (64'(pos_q) >= hi || 64'(pos_q) >= lim)) play_q = 0;
        if (rm == RM_BWD && (64'(pos_q) <= lo || pos_q == 0)) play_q = 0;
        if (rm == RM_REP && (64'(pos_q) >= hi || 64'(pos_q) >= lim)) begin
          st = si * len;
          if (st > n) st = n;
          pos_q = 33'(st << FRAC_BITS);
        end
      end
    end else if (64'(pos_q) == lim) begin
      play_q = 0;
    end

    if (!armed_q && play_q) armed_q = 1;
    if (armed_q && !play_q) begin
      armed_q = 0;
      pulse_left_q = pulse_len_q;
    end
    o.pulse = pulse_left_q != 0;
    o.playing = play_q;
    if (pulse_left_q != 0) pulse_left_q--;
    return o;
  endfunction

  // ---------------------------------------------------------------
  // Driver: drives the queued items onto the bus, random idle bursts at the falling edge
  // ---------------------------------------------------------------
  int unsigned src_gap = 0;
  int unsigned n_issued = 0;     // transactions put on the bus
  int unsigned n_accepted = 0;   // transactions taken by the block
  always @(negedge clk_i) begin
    if (rst_ni) begin
      // move on only once the presented transaction was taken
      if (!s_axis_tvalid || n_accepted == n_issued) begin
        if (src_gap != 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          voice_item_t it;
          it = pending_items.pop_front();
          n_issued++;
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= it.op;
          s_axis_tdata  <= {6'b0, it.speed, it.rst, it.conn, it.cv, it.gate,
                            it.right, it.left, it.addr};
          if (!tail_phase && $urandom_range(0, 5) == 0) src_gap = $urandom_range(1, 13);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure in bursts
  int unsigned snk_gap = 0;
  always @(negedge clk_i) begin
    if (snk_gap != 0) begin
      snk_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!tail_phase && $urandom_range(0, 6) == 0) snk_gap = $urandom_range(1, 13);
    end
  end

  // predict at input acceptance so memory and state follow transaction order
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      voice_item_t it;
      it.op = s_axis_tuser;
      {it.speed, it.rst, it.conn, it.cv, it.gate, it.right, it.left, it.addr} =
        s_axis_tdata[81:0];
      n_accepted++;
      expected_outs.insert(expected_outs.size(), voice_step(it));
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_outs.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[31:0], '0);
      end else begin
        voice_out_t w;
        w = expected_outs.pop_front();
        if (m_axis_tdata[15:0] !== w.left)
          report_mismatch("out_left", 32'(m_axis_tdata[15:0]), 32'(w.left));
        if (m_axis_tdata[31:16] !== w.right)
          report_mismatch("out_right", 32'(m_axis_tdata[31:16]), 32'(w.right));
        if (m_axis_tdata[32] !== w.pulse)
          report_mismatch("end_pulse", 32'(m_axis_tdata[32]), 32'(w.pulse));
        if (m_axis_tdata[33] !== w.playing)
          report_mismatch("playing", 32'(m_axis_tdata[33]), 32'(w.playing));
      end
    end
  end

  // watchdog: worst case is far below this
  always @(posedge clk_i) begin
    if (cycles > 64'd900000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------
  task automatic apb_write(logic [2:0] idx, logic [31:0] v);
    @(negedge clk_i);
    psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= v;
    @(negedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    write_reg(idx, v);
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // let the block drain before touching registers
  task automatic drain;
    while (pending_items.size() != 0 || expected_outs.size() != 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic voice_item_t mk_load(logic [15:0] a, logic [15:0] l, logic [15:0] r);
    voice_item_t it;
    it = '0;
    it.op = 0; it.addr = a; it.left = l; it.right = r;
    it.speed = 20'($urandom);  // ignored fields still toggle
    it.cv = 11'($urandom);
    return it;
  endfunction

  function automatic voice_item_t mk_tick(bit g, logic [10:0] cv, bit c, bit r,
                                          logic [19:0] s);
    voice_item_t it;
    it = '0;
    it.op = 1; it.gate = g; it.cv = cv; it.conn = c; it.rst = r; it.speed = s;
    it.addr = 16'($urandom); it.left = 16'($urandom); it.right = 16'($urandom);
    return it;
  endfunction

  // fill words 0..n-1 so every read stays inside written memory
  task automatic fill_samples(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      queue_item(mk_load(16'(i), 16'($urandom), 16'($urandom)));
  endtask

  function automatic logic [19:0] rnd_speed();
    case ($urandom_range(0, 3))
      0: return 20'($urandom_range(0, 13107));
      1: return 20'($urandom_range(655360, 1048575));
      default: return 20'($urandom_range(13107, 200000));
    endcase
  endfunction

  task automatic random_ticks(int unsigned k);
    bit g;
    g = 0;
    for (int unsigned i = 0; i < k; i++) begin
      if ($urandom_range(0, 7) == 0) g = ~g;
      queue_item(mk_tick(g, 11'($urandom_range(0, 1024)),
                         $urandom_range(0, 1), $urandom_range(0, 15) == 0,
                         rnd_speed()));
    end
  endtask

  initial begin
    int unsigned n_words;
    int unsigned sent;
    trig_mode_q = TM_TRIG; read_mode_q = RM_FWD; slices_q = 1; count_q = 0;
    chan_mode_q = 0; pulse_len_q = 48;
    pos_q = 0; play_q = 0; slice_q = SLICE_NONE;
    gate_q = 0; rst_q = 0; armed_q = 0; pulse_left_q = 0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty sample, then extremes of load data and tick fields
    queue_item(mk_tick(1, 11'd0, 0, 0, 20'd0));
    queue_item(mk_tick(0, 11'd1024, 1, 1, 20'hFFFFF));
    queue_item(mk_load(16'hFFFF, 16'h7FFF, 16'h8000));
    queue_item(mk_load(16'd0, 16'h8000, 16'h7FFF));
    queue_item(mk_load(16'd1, 16'h7FFF, 16'h8000));
    queue_item(mk_load(16'd2, 16'hFFFF, 16'h0000));
    drain();
    apb_write(REG_COUNT, 3);
    apb_write(REG_PULSE, 0);      // zero pulse length
    queue_item(mk_tick(1, 11'd2047, 1, 0, 20'd32768));
    queue_item(mk_tick(1, 11'd0, 1, 0, 20'd32768));
    queue_item(mk_tick(1, 11'd0, 0, 0, 20'd655360));
    queue_item(mk_tick(0, 11'd0, 0, 0, 20'd13107));
    queue_item(mk_tick(1, 11'd0, 0, 1, 20'd13107));
    drain();
    apb_write(REG_PULSE, 65535);
    apb_write(REG_READ, RM_BWD);
    queue_item(mk_tick(0, 11'd0, 0, 0, 20'd40000));
    queue_item(mk_tick(1, 11'd0, 0, 0, 20'd40000));
    queue_item(mk_tick(1, 11'd0, 0, 0, 20'd40000));
    queue_item(mk_tick(1, 11'd0, 0, 0, 20'd40000));
    drain();

    // load the whole random sample range once
    n_words = 300;
    fill_samples(n_words);
    drain();
    apb_write(REG_COUNT, n_words);

    // random phases over register settings, several extremes among them
    sent = 0;
    for (int ph = 0; ph < 17; ph++) begin
      int unsigned k;
      apb_write(REG_TRIG, (ph % 8 == 7) ? 3 : $urandom_range(0, 2));
      apb_write(REG_READ, (ph % 9 == 8) ? 3 : $urandom_range(0, 2));
      apb_write(REG_SLICE, (ph == 3) ? 0 : ((ph == 5) ? 255 :
                ((ph == 6) ? 128 : $urandom_range(1, 16))));
      apb_write(REG_CHAN, (ph % 7 == 6) ? 3 : $urandom_range(0, 2));
      apb_write(REG_PULSE, (ph == 4) ? 1 : $urandom_range(1, 60));
      apb_write(REG_COUNT, (ph == 10) ? 1 : ((ph == 11) ? 0 : $urandom_range(2, n_words)));
      if (ph == 14) tail_phase = 1;
      k = 36;
      // a few loads rewrite already-valid words mid-play
      for (int j = 0; j < 2; j++)
        queue_item(mk_load(16'($urandom_range(0, n_words - 1)),
                           16'($urandom), 16'($urandom)));
      random_ticks(k);
      sent += k;
      drain();   // sender waits for every expected result
    end

    while (expected_outs.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/sspv_pkg.sv
rtl/sspv_div.sv
rtl/sliced_sample_playback_voice.sv
tb/tb_sliced_sample_playback_voice.sv
